/* rtl/core/tcpq_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcpq_pkg
// shared types, codes and defaults of the two-class priority queue
// ----------------------------------------------------------------------------
package tcpq_pkg;

    localparam int unsigned DEF_QUEUE_DEPTH  = 16;
    localparam logic [31:0] DEF_MAX_ENTRY_ID = 32'd65535;

    localparam int unsigned ID_W     = 16;
    localparam int unsigned DEST_W   = 24;
    localparam int unsigned STATUS_W = 3;
    localparam int unsigned OCC_W    = 5;
    localparam int unsigned ADDR_W   = 3;
    localparam int unsigned DATA_W   = 32;

    // register index taken from paddr[2]
    localparam logic REG_QUEUE_KIND = 1'b0;

    typedef enum logic [1:0] {
        MODE_ADD    = 2'd0,
        MODE_REMOVE = 2'd1,
        MODE_DEPART = 2'd2,
        MODE_QUERY  = 2'd3
    } t_mode;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK       = 3'd0,
        ST_KIND     = 3'd1,
        ST_DUP      = 3'd2,
        ST_NOTFOUND = 3'd3,
        ST_EMPTY    = 3'd4,
        ST_FULL     = 3'd5
    } t_status;

    typedef enum logic {
        S_IDLE = 1'b0,
        S_EXEC = 1'b1
    } t_state;

    typedef struct packed {
        logic load;   // capture the accepted request
        logic exec;   // update the cells and load the result register
    } t_cmd;

endpackage

/* rtl/core/two_class_priority_queue_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// two_class_priority_queue_core
// ordered two-class queue with add, remove by id, depart head and query
// ----------------------------------------------------------------------------
//  channel  direction  handshake                 payload
//  in       to core    i_in_valid / o_in_stall   i_mode i_entry_id i_entry_kind
//                                                i_urgent i_dest_code
//  out      from core  o_out_valid / i_out_stall o_status o_found o_out_id
//                                                o_out_urgent o_out_dest o_occupancy
//  cfg      to core    apb psel/penable/pready   paddr pwdata prdata
//
//  each request is first captured into the request register; in the execute
//  state the cell array then compares all ids in parallel and shifts.
//  the execute state waits while the result register holds an untaken transfer.
//  reset is synchronous and clears the sequencer, the count, the result valid
//  flag and the queue kind; cell contents are left as they are.
// ----------------------------------------------------------------------------
module two_class_priority_queue_core
    import tcpq_pkg::*;
#(
    parameter int unsigned QUEUE_DEPTH  = DEF_QUEUE_DEPTH,
    parameter logic [31:0] MAX_ENTRY_ID = DEF_MAX_ENTRY_ID
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [ADDR_W-1:0]   paddr,
    input  logic [DATA_W-1:0]   pwdata,
    output logic [DATA_W-1:0]   prdata,
    output logic                pready,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  logic [1:0]          i_mode,
    input  logic [ID_W-1:0]     i_entry_id,
    input  logic                i_entry_kind,
    input  logic                i_urgent,
    input  logic [DEST_W-1:0]   i_dest_code,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output logic [STATUS_W-1:0] o_status,
    output logic                o_found,
    output logic [ID_W-1:0]     o_out_id,
    output logic                o_out_urgent,
    output logic [DEST_W-1:0]   o_out_dest,
    output logic [OCC_W-1:0]    o_occupancy
);

    t_cmd w_cmd;
    logic w_queue_kind;

    tcpq_cfg u_cfg (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .o_queue_kind (w_queue_kind)
    );

    tcpq_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_cmd       (w_cmd)
    );

    tcpq_datapath #(
        .QUEUE_DEPTH  (QUEUE_DEPTH),
        .MAX_ENTRY_ID (MAX_ENTRY_ID)
    ) u_datapath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (w_cmd),
        .i_queue_kind (w_queue_kind),
        .i_mode       (i_mode),
        .i_entry_id   (i_entry_id),
        .i_entry_kind (i_entry_kind),
        .i_urgent     (i_urgent),
        .i_dest_code  (i_dest_code),
        .o_status     (o_status),
        .o_found      (o_found),
        .o_out_id     (o_out_id),
        .o_out_urgent (o_out_urgent),
        .o_out_dest   (o_out_dest),
        .o_occupancy  (o_occupancy)
    );

endmodule

/* rtl/core/tcpq_cfg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcpq_cfg
// apb-style register port holding the accepted queue kind
// ----------------------------------------------------------------------------
module tcpq_cfg
    import tcpq_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    output logic              o_queue_kind
);

    logic r_queue_kind;
    logic w_wr;

    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_queue_kind <= 1'b0;
        end else if (w_wr && (paddr[2] == REG_QUEUE_KIND)) begin
            r_queue_kind <= pwdata[0];
        end
    end

    always_comb begin
        prdata = '0;
        unique case (paddr[2])
            REG_QUEUE_KIND: prdata = {{(DATA_W-1){1'b0}}, r_queue_kind};
            default:        prdata = '0;
        endcase
    end

    assign o_queue_kind = r_queue_kind;

endmodule

/* rtl/core/tcpq_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcpq_ctrl
// request sequencer and result valid flag
// ----------------------------------------------------------------------------
module tcpq_ctrl
    import tcpq_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_stall,
    output logic o_out_valid,
    input  logic i_out_stall,
    output t_cmd o_cmd
);

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid && i_out_stall;
        o_cmd       = '0;
        o_in_stall  = 1'b1;
        unique case (r_state)
            S_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_EXEC;
                end
            end
            S_EXEC: begin
                // result register must be free or leaving this cycle
                if (!r_out_valid || !i_out_stall) begin
                    o_cmd.exec  = 1'b1;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign o_out_valid = r_out_valid;

    a_exec_stalls_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EXEC) |-> o_in_stall)
        else $error("input not stalled while a request executes");

    a_valid_from_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(o_cmd.exec))
        else $error("result valid raised without an execute");

    a_hold_on_full_output: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EXEC && r_out_valid && i_out_stall) |=> (r_state == S_EXEC))
        else $error("request executed over a stalled result");

endmodule

/* rtl/core/tcpq_datapath.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcpq_datapath
// request register, shift-cell entry array with parallel id compare,
// entry count and result register
// ----------------------------------------------------------------------------
module tcpq_datapath
    import tcpq_pkg::*;
#(
    parameter int unsigned QUEUE_DEPTH  = DEF_QUEUE_DEPTH,
    parameter logic [31:0] MAX_ENTRY_ID = DEF_MAX_ENTRY_ID
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_cmd                i_cmd,
    input  logic                i_queue_kind,
    input  logic [1:0]          i_mode,
    input  logic [ID_W-1:0]     i_entry_id,
    input  logic                i_entry_kind,
    input  logic                i_urgent,
    input  logic [DEST_W-1:0]   i_dest_code,
    output logic [STATUS_W-1:0] o_status,
    output logic                o_found,
    output logic [ID_W-1:0]     o_out_id,
    output logic                o_out_urgent,
    output logic [DEST_W-1:0]   o_out_dest,
    output logic [OCC_W-1:0]    o_occupancy
);

    localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);

    // request register
    t_mode             r_req_mode;
    logic [ID_W-1:0]   r_req_id;
    logic              r_req_kind;
    logic              r_req_urgent;
    logic [DEST_W-1:0] r_req_dest;

    // entry cells, position 0 is the head
    logic [ID_W-1:0]   r_slot_id     [QUEUE_DEPTH];
    logic              r_slot_urgent [QUEUE_DEPTH];
    logic [DEST_W-1:0] r_slot_dest   [QUEUE_DEPTH];
    logic [ID_W-1:0]   n_slot_id     [QUEUE_DEPTH];
    logic              n_slot_urgent [QUEUE_DEPTH];
    logic [DEST_W-1:0] n_slot_dest   [QUEUE_DEPTH];

    logic [CW-1:0]     r_count, n_count;

    // result register
    t_status           r_status, n_status;
    logic              r_found, n_found;
    logic [ID_W-1:0]   r_out_id, n_out_id;
    logic              r_out_urgent, n_out_urgent;
    logic [DEST_W-1:0] r_out_dest, n_out_dest;
    logic [CW-1:0]     r_occ;

    logic [QUEUE_DEPTH-1:0] w_in_range;
    logic [QUEUE_DEPTH-1:0] w_match;
    logic [QUEUE_DEPTH-1:0] w_barrier;
    logic [QUEUE_DEPTH-1:0] w_del_sel;
    logic [QUEUE_DEPTH-1:0] w_rm_after;
    logic                   w_hit;
    logic                   w_legal;
    logic                   w_full;
    logic                   w_empty;
    logic                   w_do_ins;
    logic                   w_do_rm;
    logic [31:0]            w_occ_ext;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_req_mode   <= t_mode'(i_mode);
            r_req_id     <= i_entry_id;
            r_req_kind   <= i_entry_kind;
            r_req_urgent <= i_urgent;
            r_req_dest   <= i_dest_code;
        end
    end

    assign w_legal = (r_req_id != '0) && (32'(r_req_id) <= MAX_ENTRY_ID);
    assign w_full  = (r_count == CW'(QUEUE_DEPTH));
    assign w_empty = (r_count == '0);
    assign w_hit   = |w_match;

    assign w_del_sel = (r_req_mode == MODE_DEPART) ? QUEUE_DEPTH'(1) : w_match;

    for (genvar g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
        logic [ID_W-1:0]   w_lo_id, w_hi_id;
        logic              w_lo_urg, w_hi_urg;
        logic [DEST_W-1:0] w_lo_dest, w_hi_dest;
        logic              w_lo_bar;

        assign w_in_range[g] = (CW'(g) < r_count);
        assign w_match[g]    = w_in_range[g] && (r_slot_id[g] == r_req_id);
        // urgent entries are contiguous at the front, so the barrier is monotonic
        assign w_barrier[g]  = r_req_urgent ? !(w_in_range[g] && r_slot_urgent[g])
                                            : !w_in_range[g];
        assign w_rm_after[g] = |w_del_sel[g:0];

        if (g == 0) begin : g_head
            assign w_lo_id   = r_slot_id[g];
            assign w_lo_urg  = r_slot_urgent[g];
            assign w_lo_dest = r_slot_dest[g];
            assign w_lo_bar  = 1'b0;
        end else begin : g_body
            assign w_lo_id   = r_slot_id[g-1];
            assign w_lo_urg  = r_slot_urgent[g-1];
            assign w_lo_dest = r_slot_dest[g-1];
            assign w_lo_bar  = w_barrier[g-1];
        end

        if (g == QUEUE_DEPTH - 1) begin : g_last
            assign w_hi_id   = r_slot_id[g];
            assign w_hi_urg  = r_slot_urgent[g];
            assign w_hi_dest = r_slot_dest[g];
        end else begin : g_inner
            assign w_hi_id   = r_slot_id[g+1];
            assign w_hi_urg  = r_slot_urgent[g+1];
            assign w_hi_dest = r_slot_dest[g+1];
        end

        always_comb begin
            n_slot_id[g]     = r_slot_id[g];
            n_slot_urgent[g] = r_slot_urgent[g];
            n_slot_dest[g]   = r_slot_dest[g];
            if (w_do_ins) begin
                if (w_lo_bar) begin
                    n_slot_id[g]     = w_lo_id;
                    n_slot_urgent[g] = w_lo_urg;
                    n_slot_dest[g]   = w_lo_dest;
                end else if (w_barrier[g]) begin
                    n_slot_id[g]     = r_req_id;
                    n_slot_urgent[g] = r_req_urgent;
                    n_slot_dest[g]   = r_req_dest;
                end
            end else if (w_do_rm && w_rm_after[g]) begin
                n_slot_id[g]     = w_hi_id;
                n_slot_urgent[g] = w_hi_urg;
                n_slot_dest[g]   = w_hi_dest;
            end
        end
    end

    always_comb begin
        n_status     = ST_OK;
        n_found      = 1'b0;
        n_out_id     = '0;
        n_out_urgent = 1'b0;
        n_out_dest   = '0;
        w_do_ins     = 1'b0;
        w_do_rm      = 1'b0;
        unique case (r_req_mode)
            MODE_ADD: begin
                if (r_req_kind != i_queue_kind) begin
                    n_status = ST_KIND;
                end else if (!w_legal) begin
                    n_status = ST_FULL;
                end else if (w_hit) begin
                    n_status = ST_DUP;
                end else if (w_full) begin
                    n_status = ST_FULL;
                end else begin
                    w_do_ins = 1'b1;
                end
            end
            MODE_REMOVE: begin
                if (w_legal && w_hit) begin
                    w_do_rm = 1'b1;
                end else begin
                    n_status = ST_NOTFOUND;
                end
            end
            MODE_DEPART: begin
                if (w_empty) begin
                    n_status = ST_EMPTY;
                end else begin
                    w_do_rm      = 1'b1;
                    n_out_id     = r_slot_id[0];
                    n_out_urgent = r_slot_urgent[0];
                    n_out_dest   = r_slot_dest[0];
                end
            end
            MODE_QUERY: n_found = w_legal && w_hit;
            default:    n_status = ST_OK;
        endcase
    end

    always_comb begin
        n_count = r_count;
        if (w_do_ins) begin
            n_count = r_count + CW'(1);
        end else if (w_do_rm) begin
            n_count = r_count - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) begin
            for (int i = 0; i < QUEUE_DEPTH; i++) begin
                r_slot_id[i]     <= n_slot_id[i];
                r_slot_urgent[i] <= n_slot_urgent[i];
                r_slot_dest[i]   <= n_slot_dest[i];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_cmd.exec) begin
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) begin
            r_status     <= n_status;
            r_found      <= n_found;
            r_out_id     <= n_out_id;
            r_out_urgent <= n_out_urgent;
            r_out_dest   <= n_out_dest;
            r_occ        <= n_count;
        end
    end

    assign w_occ_ext    = 32'(r_occ);
    assign o_status     = STATUS_W'(r_status);
    assign o_found      = r_found;
    assign o_out_id     = r_out_id;
    assign o_out_urgent = r_out_urgent;
    assign o_out_dest   = r_out_dest;
    assign o_occupancy  = w_occ_ext[OCC_W-1:0];

    a_count_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(QUEUE_DEPTH))
        else $error("entry count above queue depth");

    a_add_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.exec && r_req_mode == MODE_ADD && n_status == ST_OK)
        |=> (r_count == $past(r_count) + CW'(1)))
        else $error("accepted add did not grow the count");

    a_refused_keeps_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.exec && n_status != ST_OK) |=> $stable(r_count))
        else $error("refused request changed the count");

endmodule

/* tb/tb_two_class_priority_queue_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_two_class_priority_queue_core
// self-checking bench: a mirror of the queue predicts every result, random
// idling on both channels, queue kind changed over the apb port between phases
// ----------------------------------------------------------------------------
module tb_two_class_priority_queue_core;
    import tcpq_pkg::*;

    localparam int unsigned DEPTH      = DEF_QUEUE_DEPTH;
    localparam int unsigned MAX_ID     = DEF_MAX_ENTRY_ID;
    localparam int unsigned WDOG_LIMIT = 2000;
    localparam int unsigned PHASES     = 6;
    localparam int unsigned PHASE_LEN  = 340;

    localparam logic [ADDR_W-1:0] ADDR_QUEUE_KIND = ADDR_W'(0);
    localparam logic [ADDR_W-1:0] ADDR_UNMAPPED   = ADDR_W'(4);

    typedef struct {
        t_status             status;
        logic                found;
        logic [ID_W-1:0]     id;
        logic                urg;
        logic [DEST_W-1:0]   dest;
        logic [OCC_W-1:0]    occ;
    } t_queue_result;

    class t_queue_mirror;
        logic [ID_W-1:0]   slot_ids[DEPTH];
        logic              slot_urg[DEPTH];
        logic [DEST_W-1:0] slot_dst[DEPTH];
        int unsigned       held;
        logic              kind;
        int unsigned       mismatches;
        t_queue_result     expected_results[$];

        function new();
            held = 0;
            kind = 1'b0;
            mismatches = 0;
        endfunction

        function int find_slot(logic [ID_W-1:0] id);
            for (int i = 0; i < held; i++)
                if (slot_ids[i] == id) return i;
            return -1;
        endfunction

        function bit id_legal(logic [ID_W-1:0] id);
            return id != 0 && 32'(id) <= MAX_ID;
        endfunction

        function void drop_at(int pos);
            for (int i = pos; i + 1 < held; i++) begin
                slot_ids[i] = slot_ids[i + 1];
                slot_urg[i] = slot_urg[i + 1];
                slot_dst[i] = slot_dst[i + 1];
            end
            held--;
        endfunction

        function void set_kind(logic k);
            kind = k;
        endfunction

        function int unsigned pending();
            return expected_results.size();
        endfunction

        function logic [ID_W-1:0] held_id(int unsigned idx);
            return slot_ids[idx];
        endfunction

        function void note_request(t_mode mode, logic [ID_W-1:0] id, logic ekind,
                                   logic urg, logic [DEST_W-1:0] dest);
            t_queue_result r;
            int pos;
            r.status = ST_OK;
            r.found  = 1'b0;
            r.id     = '0;
            r.urg    = 1'b0;
            r.dest   = '0;
            case (mode)
                MODE_ADD: begin
                    if (ekind != kind) r.status = ST_KIND;
                    else if (!id_legal(id)) r.status = ST_FULL;
                    else if (find_slot(id) >= 0) r.status = ST_DUP;
                    else if (held >= DEPTH) r.status = ST_FULL;
                    else begin
                        // urgent entries go right behind the last urgent one
                        pos = held;
                        if (urg) begin
                            pos = 0;
                            while (pos < held && slot_urg[pos]) pos++;
                        end
                        for (int i = held; i > pos; i--) begin
                            slot_ids[i] = slot_ids[i - 1];
                            slot_urg[i] = slot_urg[i - 1];
                            slot_dst[i] = slot_dst[i - 1];
                        end
                        slot_ids[pos] = id;
                        slot_urg[pos] = urg;
                        slot_dst[pos] = dest;
                        held++;
                    end
                end
                MODE_REMOVE: begin
                    pos = id_legal(id) ? find_slot(id) : -1;
                    if (pos >= 0) drop_at(pos);
                    else r.status = ST_NOTFOUND;
                end
                MODE_DEPART: begin
                    if (held == 0) r.status = ST_EMPTY;
                    else begin
                        r.id   = slot_ids[0];
                        r.urg  = slot_urg[0];
                        r.dest = slot_dst[0];
                        drop_at(0);
                    end
                end
                default: begin
                    r.found = id_legal(id) && find_slot(id) >= 0;
                end
            endcase
            r.occ = OCC_W'(held);
            expected_results.push_back(r);
        endfunction

        function void compare_field(string name, int unsigned exp_v, int unsigned act_v);
            if (exp_v != act_v) begin
                $display("%0t: %s mismatch: expected %0d, actual %0d",
                         $time, name, exp_v, act_v);
                mismatches++;
            end
        endfunction

        function void check_result(t_queue_result act);
            t_queue_result exp_r;
            if (expected_results.size() == 0) begin
                $display("%0t: result transfer with nothing expected: status %0d id %0d",
                         $time, act.status, act.id);
                mismatches++;
                return;
            end
            exp_r = expected_results.pop_front();
            compare_field("status", exp_r.status, act.status);
            compare_field("found", exp_r.found, act.found);
            compare_field("out_id", exp_r.id, act.id);
            compare_field("out_urgent", exp_r.urg, act.urg);
            compare_field("out_dest", exp_r.dest, act.dest);
            compare_field("occupancy", exp_r.occ, act.occ);
        endfunction
    endclass

    logic                i_clk;
    logic                i_rst_n;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [ADDR_W-1:0]   paddr;
    logic [DATA_W-1:0]   pwdata;
    logic [DATA_W-1:0]   prdata;
    logic                pready;
    logic                i_in_valid;
    logic                o_in_stall;
    logic [1:0]          i_mode;
    logic [ID_W-1:0]     i_entry_id;
    logic                i_entry_kind;
    logic                i_urgent;
    logic [DEST_W-1:0]   i_dest_code;
    logic                o_out_valid;
    logic                i_out_stall;
    logic [STATUS_W-1:0] o_status;
    logic                o_found;
    logic [ID_W-1:0]     o_out_id;
    logic                o_out_urgent;
    logic [DEST_W-1:0]   o_out_dest;
    logic [OCC_W-1:0]    o_occupancy;

    t_queue_mirror sb = new();
    bit            idle_on = 1'b1;
    int unsigned   stall_left = 0;
    int unsigned   quiet_cycles = 0;

    two_class_priority_queue_core u_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_mode       (i_mode),
        .i_entry_id   (i_entry_id),
        .i_entry_kind (i_entry_kind),
        .i_urgent     (i_urgent),
        .i_dest_code  (i_dest_code),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_status     (o_status),
        .o_found      (o_found),
        .o_out_id     (o_out_id),
        .o_out_urgent (o_out_urgent),
        .o_out_dest   (o_out_dest),
        .o_occupancy  (o_occupancy)
    );

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    // result side: random stall bursts
    always @(posedge i_clk) begin
        if (!i_rst_n || !idle_on) begin
            stall_left = 0;
            i_out_stall <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left--;
            i_out_stall <= 1'b1;
        end else if ($urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(1, 14) - 1;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    always @(posedge i_clk) begin
        t_queue_result act;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            act.status = t_status'(o_status);
            act.found  = o_found;
            act.id     = o_out_id;
            act.urg    = o_out_urgent;
            act.dest   = o_out_dest;
            act.occ    = o_occupancy;
            sb.check_result(act);
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial begin
        while (quiet_cycles < WDOG_LIMIT) @(posedge i_clk);
        $display("tb_two_class_priority_queue_core: FAIL");
        $finish;
    end

    task automatic apb_write(input logic [ADDR_W-1:0] addr, input logic [DATA_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        if (addr == ADDR_QUEUE_KIND) sb.set_kind(data[0]);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic apb_check_kind();
        logic [DATA_W-1:0] exp_v;
        exp_v = DATA_W'(sb.kind);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= ADDR_QUEUE_KIND;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        if (prdata !== exp_v) begin
            $display("%0t: queue_kind readback mismatch: expected %0d, actual %0d",
                     $time, exp_v, prdata);
            sb.mismatches++;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic send_request(input t_mode mode, input logic [ID_W-1:0] id,
                                input logic ekind, input logic urg,
                                input logic [DEST_W-1:0] dest);
        i_in_valid   <= 1'b1;
        i_mode       <= mode;
        i_entry_id   <= id;
        i_entry_kind <= ekind;
        i_urgent     <= urg;
        i_dest_code  <= dest;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        sb.note_request(mode, id, ekind, urg, dest);
        if (idle_on && $urandom_range(0, 5) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge i_clk);
        end
    endtask

    // hold the sender until every expected result has been taken
    task automatic drain_results();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending() != 0) @(posedge i_clk);
    endtask

    function automatic logic [ID_W-1:0] pick_id(bit prefer_held);
        int unsigned r;
        r = $urandom_range(0, 99);
        if (prefer_held && sb.held > 0 && r < 50)
            return sb.held_id($urandom_range(0, sb.held - 1));
        if (r < 85) return ID_W'($urandom_range(1, 20));
        if (r < 90) return '0;
        if (r < 95) return ID_W'(MAX_ID - $urandom_range(0, 1));
        return ID_W'($urandom_range(0, 65535));
    endfunction

    task automatic send_random(input int unsigned add_pct);
        int unsigned r;
        t_mode       mode;
        logic        ekind;
        r = $urandom_range(0, 99);
        if (r < add_pct) mode = MODE_ADD;
        else begin
            r = $urandom_range(0, 99);
            if (r < 35) mode = MODE_REMOVE;
            else if (r < 75) mode = MODE_DEPART;
            else mode = MODE_QUERY;
        end
        ekind = ($urandom_range(0, 99) < 92) ? sb.kind : ~sb.kind;
        send_request(mode, pick_id(mode != MODE_ADD), ekind, 1'($urandom),
                     DEST_W'($urandom));
    endtask

    initial begin
        int unsigned add_pct;
        i_rst_n      <= 1'b0;
        psel         <= 1'b0;
        penable      <= 1'b0;
        pwrite       <= 1'b0;
        paddr        <= '0;
        pwdata       <= '0;
        i_in_valid   <= 1'b0;
        i_mode       <= MODE_ADD;
        i_entry_id   <= '0;
        i_entry_kind <= 1'b0;
        i_urgent     <= 1'b0;
        i_dest_code  <= '0;
        i_out_stall  <= 1'b0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        apb_check_kind();

        // empty queue corners and add refusal order
        send_request(MODE_DEPART, 16'd0, 1'b0, 1'b0, 24'd0);
        send_request(MODE_REMOVE, 16'd5, 1'b0, 1'b0, 24'd0);
        send_request(MODE_QUERY, 16'd0, 1'b0, 1'b0, 24'd0);
        send_request(MODE_QUERY, 16'd7, 1'b0, 1'b0, 24'd0);
        send_request(MODE_ADD, 16'd0, 1'b0, 1'b0, 24'd0);
        send_request(MODE_ADD, 16'd0, 1'b1, 1'b0, 24'd0);
        send_request(MODE_ADD, 16'hFFFF, 1'b0, 1'b0, 24'hFFFFFF);
        send_request(MODE_ADD, 16'd1, 1'b0, 1'b1, 24'd0);
        send_request(MODE_REMOVE, 16'd0, 1'b0, 1'b0, 24'd0);
        send_request(MODE_QUERY, 16'hFFFF, 1'b0, 1'b0, 24'd0);
        // fill to the brim with mixed classes
        for (int i = 2; i < 16; i++)
            send_request(MODE_ADD, ID_W'(i), 1'b0, 1'(i % 3 == 0), DEST_W'(i * 24'h111111));
        send_request(MODE_ADD, 16'd100, 1'b0, 1'b1, 24'h123456);
        send_request(MODE_ADD, 16'd1, 1'b0, 1'b0, 24'h654321);
        send_request(MODE_ADD, 16'd100, 1'b1, 1'b0, 24'h000001);
        send_request(MODE_REMOVE, 16'd8, 1'b0, 1'b0, 24'd0);
        send_request(MODE_DEPART, 16'd0, 1'b0, 1'b0, 24'd0);

        for (int p = 0; p < PHASES; p++) begin
            drain_results();
            idle_on = (p != 2 && p != PHASES - 1);
            // random upper bits, kind in bit 0
            apb_write(ADDR_QUEUE_KIND, {31'($urandom), 1'(p % 2 == 0)});
            if (p == 0) apb_write(ADDR_UNMAPPED, 32'hFFFF_FFFF);
            apb_check_kind();
            case (p)
                0: add_pct = 60;
                1: add_pct = 35;
                2: add_pct = 50;
                3: add_pct = 70;
                4: add_pct = 30;
                default: add_pct = 50;
            endcase
            for (int n = 0; n < PHASE_LEN; n++) begin
                if (p == 1 && n == PHASE_LEN / 2) drain_results();
                send_random(add_pct);
            end
        end

        drain_results();
        repeat (10) @(posedge i_clk);
        if (sb.pending() != 0) begin
            $display("%0t: %0d results still expected at end", $time, sb.pending());
            sb.mismatches++;
        end
        if (sb.mismatches == 0)
            $display("tb_two_class_priority_queue_core: PASS");
        else
            $display("tb_two_class_priority_queue_core: FAIL");
        $finish;
    end

endmodule

/* files.f */
rtl/core/tcpq_pkg.sv
rtl/core/tcpq_cfg.sv
rtl/core/tcpq_ctrl.sv
rtl/core/tcpq_datapath.sv
rtl/core/two_class_priority_queue_core.sv
tb/tb_two_class_priority_queue_core.sv
